// ===== sv/first_fit_block_allocator_top_macros.svh =====
// assertion macros for the first-fit block allocator top level
// expects clk and arst_n in the scope where a macro is used
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_TOP_MACROS_SVH

// same-cycle implication
`define FFBA_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define FFBA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/ffba_pkg.sv =====
// shared types and constants of the first-fit block allocator
// no dependencies
`timescale 1ns / 1ps

package ffba_pkg;

	localparam int MAX_BLOCKS      = 64;
	localparam int HEADER_BYTES    = 8;
	localparam int HEAP_BYTES_LOG2 = 20;

	localparam int ADDR_W   = 32;
	localparam int SIZE_W   = 21;
	localparam int TOTAL_W  = SIZE_W + 1;
	localparam int IDX_W    = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
	localparam int CNT_W    = $clog2(MAX_BLOCKS + 1);
	localparam int STATUS_W = 2;
	localparam int CFG_IDX_W = 1;
	localparam int CFG_DATA_W = 32;

	localparam int IN_TDATA_W  = ((SIZE_W + ADDR_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W = ((ADDR_W + STATUS_W + 7) / 8) * 8;

	// hard ceiling of the heap, a power of two whose exponent never exceeds SIZE_W
	localparam int LIMIT_LOG2 = (HEAP_BYTES_LOG2 < SIZE_W) ? HEAP_BYTES_LOG2 : SIZE_W;
	localparam logic [TOTAL_W-1:0] LIMIT_CEIL = {{(TOTAL_W-1){1'b0}}, 1'b1} << LIMIT_LOG2;

	localparam logic [SIZE_W-1:0] CAPACITY_RESET = SIZE_W'(1048576);

	localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE     = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_HEAP_CAPACITY = 1'b1;

	typedef enum logic {
		OP_ALLOC = 1'b0,
		OP_FREE  = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK        = 2'd0,
		STATUS_FULL      = 2'd1,
		STATUS_NO_ROOM   = 2'd2,
		STATUS_UNKNOWN   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RESP
	} scan_state_t;

	typedef struct packed {
		logic              avail;
		logic [SIZE_W-1:0] size;
	} entry_t;

	typedef struct packed {
		status_t           status;
		logic [ADDR_W-1:0] granted;
	} result_t;

endpackage

// ===== sv/ffba_table_ram.sv =====
// block table memory: one write port, one read port, registered read data
// generic, no package dependency
`timescale 1ns / 1ps

module ffba_table_ram #(
	parameter int DATA_W = 22,
	parameter int DEPTH  = 64,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              wr_en,
	input  logic [ADDR_W-1:0] wr_addr,
	input  logic [DATA_W-1:0] wr_data,
	input  logic              rd_en,
	input  logic [ADDR_W-1:0] rd_addr,
	output logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== sv/ffba_scan.sv =====
// request sequencer: walks the block table one entry a cycle, then writes back on a hit or an append
// depends on ffba_pkg and ffba_table_ram
`timescale 1ns / 1ps

module ffba_scan (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  ffba_pkg::op_t               in_op,
	input  logic [ffba_pkg::SIZE_W-1:0] in_size,
	input  logic [ffba_pkg::ADDR_W-1:0] in_addr,
	input  logic [ffba_pkg::ADDR_W-1:0] heap_base,
	input  logic [ffba_pkg::SIZE_W-1:0] heap_capacity,
	output logic                        res_valid,
	input  logic                        res_take,
	output ffba_pkg::result_t           res
);

	import ffba_pkg::*;

	scan_state_t state_q, state_d;

	// request payload
	op_t                op_q;
	logic [TOTAL_W-1:0] total_q;
	logic [ADDR_W-1:0]  target_q;
	logic [SIZE_W-1:0]  start_q;
	result_t            res_q, res_d;
	logic               res_load;

	// table walk
	logic [CNT_W-1:0]   rd_idx_q;
	logic [IDX_W-1:0]   idx_s1;
	logic               pend_s1;
	logic [CNT_W-1:0]   count_q;
	logic [SIZE_W-1:0]  heap_end_q;

	logic               rd_en, wr_en, append;
	logic [IDX_W-1:0]   wr_addr;
	entry_t             rd_entry, wr_entry;

	logic               alloc_hit, free_hit, hit, scan_end;
	logic [TOTAL_W-1:0] limit;
	logic [TOTAL_W:0]   room_sum;
	logic               too_big, full;
	logic [SIZE_W-1:0]  grant_off;
	logic [ADDR_W-1:0]  grant_addr;

	ffba_table_ram #(
		.DATA_W($bits(entry_t)),
		.DEPTH (MAX_BLOCKS),
		.ADDR_W(IDX_W)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_addr),
		.wr_data(wr_entry),
		.rd_en  (rd_en),
		.rd_addr(rd_idx_q[IDX_W-1:0]),
		.rd_data(rd_entry)
	);

	assign alloc_hit = pend_s1 && (op_q == OP_ALLOC) && rd_entry.avail
		&& (TOTAL_W'(rd_entry.size) >= total_q);
	assign free_hit  = pend_s1 && (op_q == OP_FREE) && (ADDR_W'(start_q) == target_q);
	assign hit       = alloc_hit || free_hit;
	assign scan_end  = !pend_s1 && (rd_idx_q == count_q);

	assign limit    = (TOTAL_W'(heap_capacity) < LIMIT_CEIL) ? TOTAL_W'(heap_capacity)
		: LIMIT_CEIL;
	assign room_sum = (TOTAL_W+1)'(heap_end_q) + (TOTAL_W+1)'(total_q);
	assign too_big  = room_sum > (TOTAL_W+1)'(limit);
	assign full     = count_q == CNT_W'(MAX_BLOCKS);

	assign grant_off  = hit ? start_q : heap_end_q;
	assign grant_addr = heap_base + ADDR_W'(grant_off) + ADDR_W'(HEADER_BYTES);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// a write only happens in the cycle that ends the walk, when no read is issued,
	// and the next request reads only after the RESP and IDLE states have passed
	always_comb begin
		state_d          = state_q;
		in_ready         = 1'b0;
		res_valid        = 1'b0;
		rd_en            = 1'b0;
		wr_en            = 1'b0;
		append           = 1'b0;
		wr_addr          = idx_s1;
		wr_entry         = rd_entry;
		res_load         = 1'b0;
		res_d.status     = STATUS_OK;
		res_d.granted    = '0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (hit) begin
					wr_en          = 1'b1;
					wr_entry.avail = (op_q == OP_FREE);
					res_load       = 1'b1;
					state_d        = ST_RESP;
					if (op_q == OP_ALLOC) begin
						res_d.granted = grant_addr;
					end
				end else if (scan_end) begin
					res_load = 1'b1;
					state_d  = ST_RESP;
					if (op_q == OP_FREE) begin
						res_d.status = STATUS_UNKNOWN;
					end else if (full) begin
						res_d.status = STATUS_FULL;
					end else if (too_big) begin
						res_d.status = STATUS_NO_ROOM;
					end else begin
						wr_en          = 1'b1;
						append         = 1'b1;
						wr_addr        = count_q[IDX_W-1:0];
						wr_entry.avail = 1'b0;
						wr_entry.size  = total_q[SIZE_W-1:0];
						res_d.granted  = grant_addr;
					end
				end else begin
					rd_en = rd_idx_q != count_q;
				end
			end
			ST_RESP: begin
				res_valid = 1'b1;
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_s1    <= 1'b0;
			rd_idx_q   <= '0;
			count_q    <= '0;
			heap_end_q <= '0;
		end else begin
			pend_s1 <= rd_en;
			if (in_valid && in_ready) begin
				rd_idx_q <= '0;
			end else if (rd_en) begin
				rd_idx_q <= rd_idx_q + CNT_W'(1);
			end
			if (append) begin
				count_q    <= count_q + CNT_W'(1);
				heap_end_q <= room_sum[SIZE_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q     <= in_op;
			total_q  <= TOTAL_W'(in_size) + TOTAL_W'(HEADER_BYTES);
			target_q <= in_addr - heap_base - ADDR_W'(HEADER_BYTES);
			start_q  <= '0;
		end else if (pend_s1 && !hit) begin
			start_q <= start_q + rd_entry.size;
		end
		if (rd_en) begin
			idx_s1 <= rd_idx_q[IDX_W-1:0];
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign res = res_q;

endmodule

// ===== sv/first_fit_block_allocator_top.sv =====
// First-fit block allocator, no splitting and no merging. A request is taken
// only while the block is idle and walks the block table one entry per cycle
// through the single read port of the table memory, until a hit or the end of
// the blocks in use, at most all 64 table entries. The result sits in an output
// register; the next request may be accepted while it waits to be taken.
// Configuration writes are taken at any time but must only be issued while no
// request is in flight.
// depends on ffba_pkg, ffba_scan and the assertion macro header
`timescale 1ns / 1ps
`include "first_fit_block_allocator_top_macros.svh"

module first_fit_block_allocator_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// request_size [20:0], block_address [52:21], zero pad
	input  logic [ffba_pkg::IN_TDATA_W-1:0]  s_tdata,
	// operation [0]
	input  logic [0:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// granted_address [31:0], status [33:32], zero pad
	output logic [ffba_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [ffba_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ffba_pkg::CFG_DATA_W-1:0]  cfg_data
);

	import ffba_pkg::*;

	logic [ADDR_W-1:0] heap_base_q;
	logic [SIZE_W-1:0] heap_capacity_q;
	logic              m_tvalid_q;
	result_t           out_q;
	logic              res_valid, res_take;
	result_t           res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			heap_base_q     <= '0;
			heap_capacity_q <= CAPACITY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_HEAP_BASE:     heap_base_q     <= cfg_data[ADDR_W-1:0];
				REG_HEAP_CAPACITY: heap_capacity_q <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	ffba_scan u_scan (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_op        (op_t'(s_tuser[0])),
		.in_size      (s_tdata[SIZE_W-1:0]),
		.in_addr      (s_tdata[SIZE_W +: ADDR_W]),
		.heap_base    (heap_base_q),
		.heap_capacity(heap_capacity_q),
		.res_valid    (res_valid),
		.res_take     (res_take),
		.res          (res)
	);

	assign res_take = res_valid && (!m_tvalid_q || m_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_take) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(OUT_TDATA_W - ADDR_W - STATUS_W)'(0), out_q};

	`FFBA_ASSERT_SAME(a_fail_no_grant, m_tvalid_q && (out_q.status != STATUS_OK), out_q.granted == '0, "failed transaction carries an address")
	`FFBA_ASSERT_NEXT(a_accept_busy, s_tvalid && s_tready, !s_tready, "request accepted while a walk is starting")
	`FFBA_ASSERT_SAME(a_idle_no_result, s_tready, !res_valid, "result offered while idle")
	`FFBA_ASSERT_NEXT(a_take_shows, res_take, m_tvalid_q, "taken result not presented")

endmodule
